// ===== sv/lws_pkg.sv =====
// Shared types, constants and command codes of the LCD window write sequencer.
package lws_pkg;

  // Coordinate width and the derived counter and bus widths
  localparam int COORD_BITS   = 8;
  localparam int COUNT_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS   = 16;
  localparam int IN_RAW_BITS  = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;

  // Bytes per burst: window header plus one pixel
  localparam int BURST_MAX  = 13;
  localparam int BURST_IDX  = 4;
  localparam int HDR_BYTES  = 11;
  localparam int PIX_BYTES  = 2;

  // Input command codes
  localparam logic [1:0] CMD_POINT = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;

  // Display controller opcodes
  localparam logic [7:0] OP_CASET = 8'h2A;
  localparam logic [7:0] OP_RASET = 8'h2B;
  localparam logic [7:0] OP_RAMWR = 8'h2C;

  // Data/command pattern of a point burst: opcodes at bytes 0, 5 and 10
  localparam logic [BURST_MAX-1:0] HDR_DATA_MASK = 13'b1_1011_1101_1110;
  localparam logic [BURST_MAX-1:0] PIX_DATA_MASK = 13'b0_0000_0000_0011;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_SCREEN_WIDTH  = 8'd160;
  localparam logic [7:0] RST_SCREEN_HEIGHT = 8'd80;
  localparam logic [7:0] RST_COLUMN_OFFSET = 8'd1;
  localparam logic [7:0] RST_ROW_OFFSET    = 8'd26;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_COLUMN_OFFSET = 2'd2,
    REG_ROW_OFFSET    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] screen_width;
    logic [7:0] screen_height;
    logic [7:0] column_offset;
    logic [7:0] row_offset;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] color;
  } item_t;

  // Bytes caused by one input item, sent from index 0 up
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [BURST_MAX-1:0]      data_flag;
    logic [BURST_IDX-1:0]      count;
    logic                      fill_end;
  } burst_t;

endpackage

// ===== sv/lcd_window_write_sequencer.sv =====
// Top level of the LCD window write sequencer: input register, decode, byte emitter.
//
//  channel | ports                      | payload (low bit up)
//  --------+----------------------------+---------------------------------------------
//  in      | in_tvalid/in_tready        | tdata: x_start, y_start, x_end, y_end, color
//          |                            | tuser: cmd
//  out     | out_tvalid/out_tready      | tdata: out_byte; tuser: is_data, fill_end
//          |                            | tlast: last
//  cfg     | cfg_we/cfg_idx/cfg_wdata   | write only, one register per write
//
// An item is registered, decoded in the next cycle into a burst, and the burst
// leaves one word per cycle from the byte emitter while out_tready is high.
// The output words set the pace: a point sends 13 words, a fill 11, a pull
// 2, and an item that causes no word is dropped from the input register at once.
// One item waits in the input register while the emitter still sends a burst.
// Reset is synchronous and active low; it restores the register defaults and
// ends any fill. A stall on out_tready holds the word and backs up into in_tready.
module lcd_window_write_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lws_pkg::IN_DATA_BITS-1:0] in_tdata,   // x_start, y_start, x_end, y_end, color
  input  logic [1:0]                       in_tuser,   // cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // out_byte
  output logic [1:0]                       out_tuser,  // is_data, fill_end
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_idx,
  input  logic [7:0]                       cfg_wdata
);
  import lws_pkg::*;

  item_t  item_r;
  item_t  item_in;
  logic   item_valid_r;
  logic   item_valid_nxt;
  cfg_t   cfg;
  burst_t burst;
  logic   load_ok;
  logic   take;
  logic   load;
  logic   in_fire;

  // Unpack the input word
  assign item_in.cmd     = in_tuser;
  assign item_in.x_start = in_tdata[COORD_BITS-1:0];
  assign item_in.y_start = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign item_in.x_end   = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign item_in.y_end   = in_tdata[4*COORD_BITS-1:3*COORD_BITS];
  assign item_in.color   = in_tdata[IN_RAW_BITS-1:4*COORD_BITS];

  // Drop empty items at once; hand bursts over when the emitter frees up
  assign take      = item_valid_r && ((burst.count == '0) || load_ok);
  assign load      = item_valid_r && (burst.count != '0) && load_ok;
  assign in_tready = !item_valid_r || take;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_fire) begin
      item_valid_nxt = 1'b1;
    end else if (take) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_in;
    end
  end

  lws_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lws_cmd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item_r),
    .cfg   (cfg),
    .take  (take),
    .burst (burst)
  );

  lws_byte_emitter u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .burst_in   (burst),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && !take) |=> item_valid_r && $stable(item_r))
    else $error("waiting item lost or changed");
`endif

endmodule

// ===== sv/lws_cfg_regs.sv =====
// Configuration register file of the LCD window write sequencer.
module lws_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [7:0]       cfg_wdata,
  output lws_pkg::cfg_t    cfg
);
  import lws_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Write the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_wdata;
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_wdata;
        REG_COLUMN_OFFSET: cfg_nxt.column_offset = cfg_wdata;
        REG_ROW_OFFSET:    cfg_nxt.row_offset    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= RST_SCREEN_WIDTH;
      cfg_r.screen_height <= RST_SCREEN_HEIGHT;
      cfg_r.column_offset <= RST_COLUMN_OFFSET;
      cfg_r.row_offset    <= RST_ROW_OFFSET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/lws_cmd_decode.sv =====
// Command decode: builds the byte burst of one item and keeps the fill state.
module lws_cmd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  lws_pkg::item_t   item,
  input  lws_pkg::cfg_t    cfg,
  input  logic             take,
  output lws_pkg::burst_t  burst
);
  import lws_pkg::*;

  logic                  fill_active_r;
  logic                  fill_active_nxt;
  logic [COUNT_BITS-1:0] columns_left_r;
  logic [COUNT_BITS-1:0] columns_left_nxt;
  logic [COUNT_BITS-1:0] rows_left_r;
  logic [COUNT_BITS-1:0] rows_left_nxt;
  logic [COUNT_BITS-1:0] fill_span_r;
  logic [COUNT_BITS-1:0] fill_span_nxt;
  logic [COLOR_BITS-1:0] fill_color_r;
  logic [COLOR_BITS-1:0] fill_color_nxt;

  logic [COORD_BITS-1:0] x_last;
  logic [COORD_BITS-1:0] y_last;
  logic [15:0]           col_first_w;
  logic [15:0]           col_last_w;
  logic [15:0]           row_first_w;
  logic [15:0]           row_last_w;
  logic                  on_screen;
  logic                  rect_ok;
  logic [COUNT_BITS-1:0] col_dec;
  logic [COUNT_BITS-1:0] row_dec;
  logic [BURST_MAX-1:0][7:0] hdr_bytes;

  // Coordinate plus offset, zero-extended to a 16-bit address word
  function automatic logic [15:0] addr_word(input logic [COORD_BITS-1:0] c,
                                            input logic [7:0] off);
    logic [COUNT_BITS-1:0] sum;
    sum = COUNT_BITS'(c) + COUNT_BITS'(off);
    return 16'(sum);
  endfunction

  // A point's window is one pixel wide and high
  assign x_last = (item.cmd == CMD_POINT) ? item.x_start : item.x_end;
  assign y_last = (item.cmd == CMD_POINT) ? item.y_start : item.y_end;

  assign col_first_w = addr_word(item.x_start, cfg.column_offset);
  assign col_last_w  = addr_word(x_last, cfg.column_offset);
  assign row_first_w = addr_word(item.y_start, cfg.row_offset);
  assign row_last_w  = addr_word(y_last, cfg.row_offset);

  assign on_screen = (COUNT_BITS'(item.x_start) < COUNT_BITS'(cfg.screen_width)) &&
                     (COUNT_BITS'(item.y_start) < COUNT_BITS'(cfg.screen_height));
  assign rect_ok   = (item.x_end >= item.x_start) && (item.y_end >= item.y_start);

  assign col_dec = columns_left_r - COUNT_BITS'(1);
  assign row_dec = rows_left_r - COUNT_BITS'(1);

  // Window header followed by the point color
  always_comb begin
    hdr_bytes[0]  = OP_CASET;
    hdr_bytes[1]  = col_first_w[15:8];
    hdr_bytes[2]  = col_first_w[7:0];
    hdr_bytes[3]  = col_last_w[15:8];
    hdr_bytes[4]  = col_last_w[7:0];
    hdr_bytes[5]  = OP_RASET;
    hdr_bytes[6]  = row_first_w[15:8];
    hdr_bytes[7]  = row_first_w[7:0];
    hdr_bytes[8]  = row_last_w[15:8];
    hdr_bytes[9]  = row_last_w[7:0];
    hdr_bytes[10] = OP_RAMWR;
    hdr_bytes[11] = item.color[15:8];
    hdr_bytes[12] = item.color[7:0];
  end

  // Select the burst and the next fill state per command
  always_comb begin
    burst            = '0;
    fill_active_nxt  = fill_active_r;
    columns_left_nxt = columns_left_r;
    rows_left_nxt    = rows_left_r;
    fill_span_nxt    = fill_span_r;
    fill_color_nxt   = fill_color_r;
    case (item.cmd)
      CMD_POINT: begin
        if (on_screen) begin
          burst.bytes     = hdr_bytes;
          burst.data_flag = HDR_DATA_MASK;
          burst.count     = BURST_IDX'(BURST_MAX);
        end
      end
      CMD_FILL: begin
        burst.bytes     = hdr_bytes;
        burst.data_flag = HDR_DATA_MASK;
        burst.count     = BURST_IDX'(HDR_BYTES);
        if (rect_ok) begin
          fill_span_nxt    = COUNT_BITS'(item.x_end) - COUNT_BITS'(item.x_start)
                             + COUNT_BITS'(1);
          columns_left_nxt = fill_span_nxt;
          rows_left_nxt    = COUNT_BITS'(item.y_end) - COUNT_BITS'(item.y_start)
                             + COUNT_BITS'(1);
          fill_color_nxt   = item.color;
          fill_active_nxt  = 1'b1;
        end else begin
          fill_active_nxt  = 1'b0;
          fill_span_nxt    = '0;
          columns_left_nxt = '0;
          rows_left_nxt    = '0;
        end
      end
      CMD_PULL: begin
        if (fill_active_r) begin
          burst.bytes[0]   = fill_color_r[15:8];
          burst.bytes[1]   = fill_color_r[7:0];
          burst.data_flag  = PIX_DATA_MASK;
          burst.count      = BURST_IDX'(PIX_BYTES);
          columns_left_nxt = col_dec;
          // End of a row: reload the span and step the row count
          if (col_dec == '0) begin
            columns_left_nxt = fill_span_r;
            rows_left_nxt    = row_dec;
            if (row_dec == '0) begin
              fill_active_nxt  = 1'b0;
              columns_left_nxt = '0;
              burst.fill_end   = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_active_r  <= 1'b0;
      columns_left_r <= '0;
      rows_left_r    <= '0;
      fill_span_r    <= '0;
      fill_color_r   <= '0;
    end else if (take) begin
      fill_active_r  <= fill_active_nxt;
      columns_left_r <= columns_left_nxt;
      rows_left_r    <= rows_left_nxt;
      fill_span_r    <= fill_span_nxt;
      fill_color_r   <= fill_color_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_active_counts: assert property (@(posedge clk) disable iff (!rst_n)
    fill_active_r |-> (columns_left_r != '0) && (rows_left_r != '0))
    else $error("active fill with an empty column or row count");

  a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_active_r |-> columns_left_r <= fill_span_r)
    else $error("columns left exceed the fill span");
`endif

endmodule

// ===== sv/lws_byte_emitter.sv =====
// Byte emitter: holds one burst and sends it one word per cycle while out_tready is high.
module lws_byte_emitter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  lws_pkg::burst_t  burst_in,
  output logic             load_ok,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import lws_pkg::*;

  burst_t               burst_r;
  logic                 valid_r;
  logic                 valid_nxt;
  logic [BURST_IDX-1:0] idx_r;
  logic [BURST_IDX-1:0] idx_nxt;
  logic                 at_last;
  logic                 send;

  assign at_last = (idx_r == burst_r.count - BURST_IDX'(1));
  assign send    = valid_r && out_tready;
  // Free, or the final word leaves this cycle
  assign load_ok = !valid_r || (send && at_last);

  // Advance through the burst, or take a new one
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (send) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + BURST_IDX'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst_in;
    end
  end

  assign out_tvalid   = valid_r;
  assign out_tdata    = burst_r.bytes[idx_r];
  assign out_tuser[0] = burst_r.data_flag[idx_r];
  assign out_tuser[1] = burst_r.fill_end && at_last;
  assign out_tlast    = at_last;

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r < burst_r.count) && (burst_r.count != '0))
    else $error("byte index beyond the burst");

  a_fill_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("fill end flagged on a word that is not last");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the LCD window write sequencer: stream traffic against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import lws_pkg::*;

  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int PRINT_LIMIT    = 30;

  // The one command code the block has no name for; it must be ignored
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One byte toward the display with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
    logic       fill_end;
  } lcd_word_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_BITS-1:0] in_tdata   = '0;         // x_start, y_start, x_end, y_end, color
  logic [1:0]              in_tuser   = CMD_POINT;  // cmd
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [7:0]              out_tdata;               // out_byte
  logic [1:0]              out_tuser;               // is_data, fill_end
  logic                    out_tlast;
  logic                    cfg_we     = 1'b0;
  logic [1:0]              cfg_idx    = REG_SCREEN_WIDTH;
  logic [7:0]              cfg_wdata  = '0;

  lcd_window_write_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor copy of the registers and the fill state
  logic [7:0]            scr_width  = RST_SCREEN_WIDTH;
  logic [7:0]            scr_height = RST_SCREEN_HEIGHT;
  logic [7:0]            col_off    = RST_COLUMN_OFFSET;
  logic [7:0]            row_off    = RST_ROW_OFFSET;
  logic                  fill_on    = 1'b0;
  logic [COUNT_BITS-1:0] cols_left  = '0;
  logic [COUNT_BITS-1:0] rows_left  = '0;
  logic [COUNT_BITS-1:0] fill_span  = '0;
  logic [COLOR_BITS-1:0] fill_rgb   = '0;

  lcd_word_t burst_buf [BURST_MAX];
  int        burst_len;
  lcd_word_t byte_expect [$];
  item_t     pending_items [$];

  int settings_used = 1;
  int items_taken   = 0;
  int results_seen  = 0;
  int fills_done    = 0;
  int errors        = 0;

  task automatic put_byte(logic [7:0] value, logic data_flag);
    burst_buf[burst_len] = '{data: value, is_data: data_flag, last: 1'b0, fill_end: 1'b0};
    burst_len++;
  endtask

  // Two data bytes, high first
  task automatic put_pair(logic [15:0] value);
    put_byte(value[15:8], 1'b1);
    put_byte(value[7:0], 1'b1);
  endtask

  // Address window: column set, row set, memory write
  task automatic put_window(logic [7:0] xs, logic [7:0] ys, logic [7:0] xe, logic [7:0] ye);
    put_byte(OP_CASET, 1'b0);
    put_pair(16'(xs) + 16'(col_off));
    put_pair(16'(xe) + 16'(col_off));
    put_byte(OP_RASET, 1'b0);
    put_pair(16'(ys) + 16'(row_off));
    put_pair(16'(ye) + 16'(row_off));
    put_byte(OP_RAMWR, 1'b0);
  endtask

  // Work out the bytes one accepted item causes and queue them
  task automatic predict_bytes(item_t it);
    logic done;
    done      = 1'b0;
    burst_len = 0;
    case (it.cmd)
      CMD_POINT: begin
        if (it.x_start < scr_width && it.y_start < scr_height) begin
          put_window(it.x_start, it.y_start, it.x_start, it.y_start);
          put_pair(it.color);
        end
      end
      CMD_FILL: begin
        put_window(it.x_start, it.y_start, it.x_end, it.y_end);
        if (it.x_end >= it.x_start && it.y_end >= it.y_start) begin
          fill_span = COUNT_BITS'(it.x_end) - COUNT_BITS'(it.x_start) + 1'b1;
          cols_left = fill_span;
          rows_left = COUNT_BITS'(it.y_end) - COUNT_BITS'(it.y_start) + 1'b1;
          fill_rgb  = it.color;
          fill_on   = 1'b1;
        end else begin
          fill_on   = 1'b0;
          fill_span = '0;
          cols_left = '0;
          rows_left = '0;
        end
      end
      CMD_PULL: begin
        if (fill_on) begin
          put_pair(fill_rgb);
          cols_left = cols_left - 1'b1;
          if (cols_left == 0) begin
            cols_left = fill_span;
            rows_left = rows_left - 1'b1;
            if (rows_left == 0) begin
              fill_on   = 1'b0;
              cols_left = '0;
              done      = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    if (burst_len > 0) begin
      burst_buf[burst_len-1].last     = 1'b1;
      burst_buf[burst_len-1].fill_end = done;
      for (int i = 0; i < burst_len; i++) byte_expect.push_back(burst_buf[i]);
    end
  endtask

  // Sender: bursts of words with gaps, fed from the pending queue
  item_t       drv_item;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  bit          steady     = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_bytes(drv_item);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drv_item = pending_items.pop_front();
          in_tdata <= {drv_item.color, drv_item.y_end, drv_item.x_end,
                       drv_item.y_start, drv_item.x_start};
          in_tuser  <= drv_item.cmd;
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = steady ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each word, then pick the next ready from a changing pattern
  int unsigned hold_left    = 0;
  int unsigned rx_tick      = 0;
  int unsigned rx_mode      = 0;
  int          next_hold_at = 40;
  lcd_word_t   got;
  lcd_word_t   want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{data: out_tdata, is_data: out_tuser[0], last: out_tlast,
                fill_end: out_tuser[1]};
        results_seen++;
        if (got.fill_end) fills_done++;
        if (byte_expect.size() == 0) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display({"%0t: unexpected word, expected none, ",
                      "got byte %02h data %0b last %0b end %0b"},
                     $time, got.data, got.is_data, got.last, got.fill_end);
        end else begin
          want = byte_expect.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= PRINT_LIMIT)
              $display({"%0t: expected byte %02h data %0b last %0b end %0b, ",
                        "got byte %02h data %0b last %0b end %0b"},
                       $time, want.data, want.is_data, want.last, want.fill_end,
                       got.data, got.is_data, got.last, got.fill_end);
          end
        end
      end
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
      // Hold off long enough for the block to back up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (results_seen >= next_hold_at && pending_items.size() > 8) begin
        hold_left    = LONG_HOLD - 1;
        next_hold_at = next_hold_at + 1500;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 2) == 0);
          default: out_tready <= ((rx_tick / 3) % 2 == 0);
        endcase
      end
    end
  end

  // Watchdog: no word moves while work is outstanding
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (pending_items.size() == 0 && !in_tvalid && byte_expect.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
      $display("[lcd_window_write_sequencer] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Random byte and color values
  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic void push_item(logic [1:0] cmd, logic [7:0] xs, logic [7:0] ys,
                                    logic [7:0] xe, logic [7:0] ye, logic [15:0] rgb);
    item_t it;
    it.cmd     = cmd;
    it.x_start = xs;
    it.y_start = ys;
    it.x_end   = xe;
    it.y_end   = ye;
    it.color   = rgb;
    pending_items.push_back(it);
  endfunction

  // Queue a point, mostly on screen; report whether it lands on screen
  function automatic bit push_point();
    logic [7:0] x;
    logic [7:0] y;
    if (scr_width != 0 && scr_height != 0 && $urandom_range(0, 3) != 0) begin
      x = 8'($urandom_range(0, scr_width - 1));
      y = 8'($urandom_range(0, scr_height - 1));
    end else begin
      x = rnd8();
      y = rnd8();
    end
    push_item(CMD_POINT, x, y, rnd8(), rnd8(), rnd16());
    return (x < scr_width && y < scr_height);
  endfunction

  // Mostly small fills followed by their pulls, with points and noise mixed in
  task automatic make_random(int target);
    int         counted;
    int         pick;
    int         w;
    int         h;
    int         pixels;
    logic [7:0] xs;
    logic [7:0] ys;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        w      = $urandom_range(1, 4);
        h      = $urandom_range(1, 4);
        xs     = 8'($urandom_range(0, 256 - w));
        ys     = 8'($urandom_range(0, 256 - h));
        pixels = w * h;
        if ($urandom_range(0, 6) == 0) pixels = $urandom_range(0, pixels - 1);
        push_item(CMD_FILL, xs, ys, 8'(xs + w - 1), 8'(ys + h - 1), rnd16());
        for (int n = 0; n < pixels; n++) begin
          if ($urandom_range(0, 9) == 0) void'(push_point());
          push_item(CMD_PULL, rnd8(), rnd8(), rnd8(), rnd8(), rnd16());
        end
        counted += 1 + pixels;
      end else if (pick < 80) begin
        counted += int'(push_point());
      end else if (pick < 88) begin
        // Unbounded and often reversed rectangle, left unfinished
        push_item(CMD_FILL, rnd8(), rnd8(), rnd8(), rnd8(), rnd16());
        pixels = $urandom_range(0, 3);
        repeat (pixels) push_item(CMD_PULL, rnd8(), rnd8(), rnd8(), rnd8(), rnd16());
        counted += 1 + pixels;
      end else if (pick < 94) begin
        push_item(CMD_PULL, rnd8(), rnd8(), rnd8(), rnd8(), rnd16());
      end else begin
        push_item(CMD_UNUSED, rnd8(), rnd8(), rnd8(), rnd8(), rnd16());
      end
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_SCREEN_WIDTH:  scr_width  = value;
      REG_SCREEN_HEIGHT: scr_height = value;
      REG_COLUMN_OFFSET: col_off    = value;
      default:           row_off    = value;
    endcase
  endtask

  task automatic apply_settings(logic [7:0] w, logic [7:0] h, logic [7:0] co, logic [7:0] ro);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_COLUMN_OFFSET, co);
    write_reg(REG_ROW_OFFSET, ro);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Wait until every word is out, then let any word-less item settle
  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || byte_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings
    push_item(CMD_POINT, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000);
    push_item(CMD_POINT, 8'd159, 8'd79, 8'd0, 8'd0, 16'hFFFF);
    push_item(CMD_POINT, 8'd160, 8'd0, 8'd0, 8'd0, 16'h1111);
    push_item(CMD_POINT, 8'd0, 8'd80, 8'd0, 8'd0, 16'h2222);
    push_item(CMD_POINT, 8'd255, 8'd255, 8'd255, 8'd255, 16'hA5A5);
    push_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    push_item(CMD_PULL, 8'd1, 8'd1, 8'd1, 8'd1, 16'h3333);
    push_item(CMD_FILL, 8'd2, 8'd3, 8'd3, 8'd4, 16'h1234);
    push_item(CMD_PULL, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF);
    push_item(CMD_POINT, 8'd10, 8'd10, 8'd0, 8'd0, 16'hBEEF);
    repeat (3) push_item(CMD_PULL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0F0F);
    push_item(CMD_PULL, 8'd0, 8'd0, 8'd0, 8'd0, 16'h4444);
    push_item(CMD_FILL, 8'd5, 8'd0, 8'd4, 8'd0, 16'h5555);
    push_item(CMD_PULL, 8'd0, 8'd0, 8'd0, 8'd0, 16'h6666);
    push_item(CMD_FILL, 8'd0, 8'd5, 8'd0, 8'd4, 16'h7777);
    push_item(CMD_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 16'h5A5A);
    push_item(CMD_PULL, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000);
    push_item(CMD_FILL, 8'd250, 8'd250, 8'd255, 8'd250, 16'hC3C3);
    repeat (6) push_item(CMD_PULL, 8'd0, 8'd0, 8'd0, 8'd0, 16'h8888);
    drain();

    // Random phases over several register settings, extremes first
    apply_settings(8'd255, 8'd255, 8'd255, 8'd255);
    steady = 1'b1;
    make_random(60);
    drain();

    apply_settings(8'd1, 8'd1, 8'd0, 8'd0);
    steady = 1'b0;
    make_random(50);
    drain();

    apply_settings(8'd0, 8'd0, 8'd7, 8'd200);
    make_random(40);
    drain();

    apply_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), rnd8(), rnd8());
    make_random(60);
    drain();

    apply_settings(RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_COLUMN_OFFSET, RST_ROW_OFFSET);
    make_random(60);
    drain();

    $display("Covered %0d input words under %0d register settings.", items_taken, settings_used);
    $display("Checked %0d output words; %0d rectangles ran to their end.",
             results_seen, fills_done);
    if (errors == 0) begin
      $display("[lcd_window_write_sequencer] OK");
    end else begin
      $display("[lcd_window_write_sequencer] ERROR");
    end
    $finish;
  end

endmodule
